>>> src/framed_packet_receiver_assert.svh
// Assertion macros for the framed packet receiver RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define FPR_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define FPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fpr_pkg.sv
// Package for the framed packet receiver: widths, reset values, codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package fpr_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 7;
  localparam int unsigned IDX_W           = 6;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned SUM_W           = 16;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'h03;
  localparam logic [BYTE_W-1:0] SEED_RST       = 8'h55;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 7'd64;
  localparam logic [LEN_W-1:0]  LEN_SAT        = 7'h7f;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_SUM_ERR = 3'd2,
    KIND_END_ERR = 3'd3,
    KIND_LEN_ERR = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_LENGTH,
    ST_DATA,
    ST_SUM_LO,
    ST_SUM_HI,
    ST_END,
    ST_RD,
    ST_LD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  take_len;
    logic  take_data;
    logic  emit;
    kind_t emit_kind;
    logic  rd_start;
    logic  rd_issue;
    logic  rd_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic len_big;
    logic len_zero;
    logic data_done;
    logic lo_match;
    logic hi_match;
    logic exp_zero;
    logic rp_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> src/fpr_rx_if.sv
// Input byte channel: valid/ready handshake carrying one received byte.
// Depends on fpr_pkg.
`default_nettype none

interface fpr_rx_if import fpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> src/fpr_res_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on fpr_pkg.
`default_nettype none

interface fpr_res_if import fpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [IDX_W-1:0]  byte_index;
  logic [LEN_W-1:0]  frame_length;
  logic              last;

  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output frame_length, output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input byte_index,
                  input frame_length, input last, output ready);
endinterface

`default_nettype wire

>>> src/fpr_datapath.sv
// Datapath of the framed packet receiver: config registers, length and
// checksum tracking, payload store, replay read and output register. Uses fpr_pkg.
`default_nettype none

module fpr_datapath import fpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [KIND_W-1:0]    out_kind,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [IDX_W-1:0]     out_byte_index,
  output logic [LEN_W-1:0]     out_frame_length,
  output logic                 out_last
);

  // Lengths never exceed 127, so deeper storage is never addressed
  localparam int unsigned DEPTH = (MAX_PAYLOAD < 127) ? MAX_PAYLOAD : 127;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [BYTE_W-1:0] start_char_r, end_char_r, seed_r;
  logic [LEN_W-1:0]  max_len_r;
  logic [LEN_W-1:0]  exp_len_r, exp_len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  rp_r, rp_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] mem [DEPTH];

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;

  logic [LEN_W-1:0]  len_sat;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= START_CHAR_RST;
      end_char_r   <= END_CHAR_RST;
      seed_r       <= SEED_RST;
      max_len_r    <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_CHAR: start_char_r <= cfg_data;
        CFG_END_CHAR:   end_char_r   <= cfg_data;
        CFG_SEED:       seed_r       <= cfg_data;
        CFG_MAX_LEN:    max_len_r    <= cfg_data[LEN_W-1:0];
        default:        ;
      endcase
    end
  end

  // Status toward the controller
  always_comb begin
    sts.is_start  = (rx_byte == start_char_r);
    sts.is_end    = (rx_byte == end_char_r);
    sts.len_big   = (rx_byte > {1'b0, max_len_r}) ||
                    ({1'b0, rx_byte} > 9'(MAX_PAYLOAD));
    sts.len_zero  = (rx_byte == '0);
    sts.data_done = (({1'b0, cnt_r} + 8'd1) >= {1'b0, exp_len_r});
    sts.lo_match  = (rx_byte == sum_r[7:0]);
    sts.hi_match  = (rx_byte == sum_r[15:8]);
    sts.exp_zero  = (exp_len_r == '0);
    sts.rp_last   = (({1'b0, rp_r} + 8'd1) == {1'b0, exp_len_r});
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign len_sat = rx_byte[BYTE_W-1] ? LEN_SAT : rx_byte[LEN_W-1:0];

  // Frame tracking: length, count, checksum, replay pointer
  always_comb begin
    exp_len_nxt = exp_len_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    rp_nxt      = rp_r;
    if (cmd.take_len) begin
      exp_len_nxt = rx_byte[LEN_W-1:0];
      cnt_nxt     = '0;
      sum_nxt     = SUM_W'(seed_r) + SUM_W'(rx_byte);
    end
    if (cmd.take_data) begin
      cnt_nxt = cnt_r + 7'd1;
      sum_nxt = sum_r + SUM_W'(rx_byte);
    end
    if (cmd.rd_start) rp_nxt = '0;
    if (cmd.rd_load)  rp_nxt = rp_r + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      rp_r      <= '0;
    end else begin
      exp_len_r <= exp_len_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      rp_r      <= rp_nxt;
    end
  end

  // Payload store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take_data) mem[cnt_r[AW-1:0]] <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rdata_r <= mem[rp_r[AW-1:0]];
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = cmd.emit_kind;
      out_byte_nxt  = '0;
      out_idx_nxt   = '0;
      out_last_nxt  = 1'b1;
      case (cmd.emit_kind)
        KIND_LEN_ERR: out_len_nxt = len_sat;
        KIND_EMPTY:   out_len_nxt = '0;
        default:      out_len_nxt = exp_len_r;
      endcase
    end else if (cmd.rd_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_PAYLOAD;
      out_byte_nxt  = rdata_r;
      out_idx_nxt   = rp_r[IDX_W-1:0];
      out_len_nxt   = exp_len_r;
      out_last_nxt  = sts.rp_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_frame_length = out_len_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

>>> src/fpr_ctrl.sv
// Controller of the framed packet receiver: parse and replay state machine.
// Uses fpr_pkg and the assertion macros in framed_packet_receiver_assert.svh.
`default_nettype none

`include "framed_packet_receiver_assert.svh"

module fpr_ctrl import fpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  // Input ready: phases that never emit need no free output slot
  always_comb begin
    case (state_r)
      ST_START, ST_DATA:                  in_ready = 1'b1;
      ST_LENGTH, ST_SUM_LO, ST_SUM_HI,
      ST_END:                             in_ready = sts.out_free;
      default:                            in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_START: begin
        if (accept && sts.is_start) state_nxt = ST_LENGTH;
      end
      ST_LENGTH: begin
        if (accept) begin
          if (sts.len_big)       state_nxt = ST_START;
          else if (sts.len_zero) state_nxt = ST_SUM_LO;
          else                   state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (accept && sts.data_done) state_nxt = ST_SUM_LO;
      end
      ST_SUM_LO: begin
        if (accept) begin
          if (sts.lo_match)      state_nxt = ST_SUM_HI;
          else if (sts.is_start) state_nxt = ST_LENGTH;
          else                   state_nxt = ST_START;
        end
      end
      ST_SUM_HI: begin
        if (accept) begin
          if (sts.hi_match)      state_nxt = ST_END;
          else if (sts.is_start) state_nxt = ST_LENGTH;
          else                   state_nxt = ST_START;
        end
      end
      ST_END: begin
        if (accept) begin
          if (sts.is_end && !sts.exp_zero) state_nxt = ST_RD;
          else                             state_nxt = ST_START;
        end
      end
      ST_RD: state_nxt = ST_LD;
      ST_LD: begin
        if (sts.out_free) state_nxt = sts.rp_last ? ST_START : ST_RD;
      end
      default: state_nxt = ST_START;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.emit_kind = KIND_PAYLOAD;
    case (state_r)
      ST_LENGTH: begin
        if (accept) begin
          if (sts.len_big) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_LEN_ERR;
          end else begin
            cmd.take_len = 1'b1;
          end
        end
      end
      ST_DATA: cmd.take_data = accept;
      ST_SUM_LO: begin
        if (accept && !sts.lo_match) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_SUM_ERR;
        end
      end
      ST_SUM_HI: begin
        if (accept && !sts.hi_match) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_SUM_ERR;
        end
      end
      ST_END: begin
        if (accept) begin
          if (!sts.is_end) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_END_ERR;
          end else if (sts.exp_zero) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_EMPTY;
          end else begin
            cmd.rd_start = 1'b1;
          end
        end
      end
      ST_RD: cmd.rd_issue = 1'b1;
      ST_LD: cmd.rd_load  = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks
  `FPR_ASSERT_ALWAYS(a_load_needs_slot, clk, rst_n, !(cmd.emit || cmd.rd_load) || sts.out_free, "result loaded into a busy output register")
  `FPR_ASSERT_ALWAYS(a_no_double_load, clk, rst_n, !(cmd.emit && cmd.rd_load), "status and replay loaded together")
  `FPR_ASSERT_NEXT(a_read_then_load, clk, rst_n, cmd.rd_issue, state_r == ST_LD, "replay read not followed by load")
  `FPR_ASSERT_NEXT(a_replay_blocks_input, clk, rst_n, cmd.rd_start, !in_ready, "input taken during payload replay")

endmodule

`default_nettype wire

>>> src/framed_packet_receiver.sv
// Top level of the framed packet receiver: controller plus datapath.
// Depends on fpr_pkg, fpr_rx_if, fpr_res_if, fpr_ctrl and fpr_datapath.
//
//   channel   direction  handshake      contents
//   in_rx     in         valid/ready    rx_byte
//   out_res   out        valid/ready    kind, payload_byte, byte_index, frame_length, last
//   cfg_*     in         cfg_we only    cfg_index, cfg_data
//
// A byte is taken while in_ready is high; the output register decouples the sides.
// A good end byte of a non-empty frame starts a replay of the L stored bytes, each via
// ST_RD (registered read of the payload store) and ST_LD; no input is taken in replay.
// out_ready low holds the output register and, while it is full, stalls bytes that
// may produce a result. Reset is synchronous, with no clearing pass.
`default_nettype none

module framed_packet_receiver import fpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fpr_rx_if.sink               in_rx,
  fpr_res_if.source            out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Parse/replay controller
  fpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_rx.valid),
    .in_ready (in_rx.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Registers, store and output stage
  fpr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_byte          (in_rx.rx_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_res.ready),
    .out_valid        (out_res.valid),
    .out_kind         (out_res.kind),
    .out_payload_byte (out_res.payload_byte),
    .out_byte_index   (out_res.byte_index),
    .out_frame_length (out_res.frame_length),
    .out_last         (out_res.last)
  );

endmodule

`default_nettype wire
